// File: design/char_lcd_number_writer_assert.svh
// ----------------------------------------------------------------------------
// char_lcd_number_writer_assert.svh : assertion macros for the LCD writer
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NUMBER_WRITER_ASSERT_SVH
`define CHAR_LCD_NUMBER_WRITER_ASSERT_SVH

// same-cycle implication
`define CNW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CNW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cnw_pkg.sv
// ----------------------------------------------------------------------------
// cnw_pkg : shared types and constants for the LCD number writer
// Request modes, job kinds, sequencer states and the LCD command bytes.
// ----------------------------------------------------------------------------
package cnw_pkg;

  // request modes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CURSOR = 3'd1;
  localparam logic [2:0] MODE_UDEC   = 3'd2;
  localparam logic [2:0] MODE_SDEC   = 3'd3;
  localparam logic [2:0] MODE_HEX    = 3'd4;
  localparam logic [2:0] MODE_BIN    = 3'd5;

  localparam logic [1:0] LINE_FIRST = 2'd1;

  // LCD command and character bytes
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_DDRAM        = 8'h80;
  localparam logic [7:0] LINE2_OFFSET     = 8'h40;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;
  localparam logic [7:0] ASCII_ALPHA_BASE = 8'h37;  // 'A' - 10
  localparam logic [7:0] ASCII_PLUS       = 8'h2B;
  localparam logic [7:0] ASCII_MINUS      = 8'h2D;

  localparam logic [1:0] INIT_LAST_IDX = 2'd3;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef enum logic [2:0] {
    KIND_INIT,
    KIND_CURSOR,
    KIND_UDEC,
    KIND_SDEC,
    KIND_HEX,
    KIND_BIN
  } cnw_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_INIT,
    ST_CURSOR,
    ST_SIGN,
    ST_DIGIT
  } cnw_state_t;

  typedef struct packed {
    cnw_kind_t  kind;
    logic       neg;
    logic [7:0] cursor;
  } cnw_job_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cnw_q_stat_t;

  typedef struct packed {
    logic busy;
  } cnw_back_stat_t;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CMD_FUNCTION_SET;
      2'd1:    b = CMD_DISPLAY_ON;
      2'd2:    b = CMD_ENTRY_MODE;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    return (d < 4'd10) ? (ASCII_ZERO + 8'(d)) : (ASCII_ALPHA_BASE + 8'(d));
  endfunction

endpackage

// File: design/cnw_if.sv
// ----------------------------------------------------------------------------
// cnw_if : request and LCD write channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface cnw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [1:0]  line;
  logic [5:0]  column;
  logic [15:0] number;
  logic [4:0]  digit_count;

  modport source(output valid, mode, line, column, number, digit_count, input ready);
  modport sink(input valid, mode, line, column, number, digit_count, output ready);
endinterface

interface cnw_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_byte;
  logic       last;

  modport source(output valid, reg_select, bus_byte, last, input ready);
  modport sink(input valid, reg_select, bus_byte, last, output ready);
endinterface

// File: design/char_lcd_number_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_number_writer : turns requests into runs of character-LCD writes
// Path: a request is queued, fetched by the idle sequencer, converted to BCD
// in the decimal modes, and then its first write is registered for the LCD.
// Throughput: one write per cycle while the LCD side is ready; each request
// also spends a fetch and, in the decimal modes, the BCD conversion steps.
// Reset (sync, rst_n low) empties the job queue and idles the sequencer.
// ----------------------------------------------------------------------------
`include "char_lcd_number_writer_assert.svh"

module char_lcd_number_writer #(
  parameter int MAX_DIGITS   = 16,
  parameter int NUMBER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cnw_in_if.sink     in_ch,
  cnw_out_if.source  out_ch
);
  import cnw_pkg::*;

  // width of the saturated digit count
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  // one queued job: control word, value (magnitude in signed mode), count
  localparam int JOB_W = $bits(cnw_job_ctrl_t) + NUMBER_WIDTH + CW;

  cnw_q_stat_t             q_stat;
  cnw_back_stat_t          back_stat;
  logic                    q_push;
  logic                    q_pop;

  cnw_job_ctrl_t           f_ctrl;
  logic [NUMBER_WIDTH-1:0] f_value;
  logic [CW-1:0]           f_count;

  cnw_job_ctrl_t           b_ctrl;
  logic [NUMBER_WIDTH-1:0] b_value;
  logic [CW-1:0]           b_count;

  logic [JOB_W-1:0]        q_wdata;
  logic [JOB_W-1:0]        q_rdata;

  // Front end: takes a transaction whenever the queue has room, drops the
  // unused modes, and hands the sequencer a ready-made job.
  cnw_front #(
    .MAX_DIGITS   (MAX_DIGITS),
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .CW           (CW)
  ) u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (q_push),
    .job_ctrl  (f_ctrl),
    .job_value (f_value),
    .job_count (f_count)
  );

  assign q_wdata = {f_ctrl, f_value, f_count};

  // Two-entry queue so the front keeps taking requests while the
  // sequencer is still emitting the previous one.
  cnw_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign {b_ctrl, b_value, b_count} = q_rdata;

  // Back end: the write sequencer with its output register; a finished
  // write waits there while the sequencer prepares the next.
  cnw_back #(
    .MAX_DIGITS   (MAX_DIGITS),
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .CW           (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job_ctrl  (b_ctrl),
    .job_value (b_value),
    .job_count (b_count),
    .pop       (q_pop),
    .stat      (back_stat),
    .out_ch    (out_ch)
  );

  // A write that is not the last of its request means the sequencer is mid-job.
  `CNW_ASSERT_IMP(a_open_job_busy, out_ch.valid && !out_ch.last, back_stat.busy, "open write while sequencer idle")
  // Queue must never be pushed when full nor popped when empty.
  `CNW_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "push into full job queue")
  `CNW_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty job queue")
  // Fetching a job always starts the sequencer.
  `CNW_ASSERT_NEXT(a_pop_starts, q_pop, back_stat.busy, "job fetched but sequencer idle")

endmodule

// File: design/cnw_queue.sv
// ----------------------------------------------------------------------------
// cnw_queue : two-entry job queue
// Decouples request classification from the write sequencer.
// ----------------------------------------------------------------------------
module cnw_queue #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output cnw_pkg::cnw_q_stat_t stat
);
  import cnw_pkg::*;

  localparam logic [1:0] FULL_CNT = 2'd2;

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/cnw_front.sv
// ----------------------------------------------------------------------------
// cnw_front : request intake and classification
// Decodes the mode, builds the cursor command, saturates the digit count
// and takes the magnitude of signed values before queueing the job.
// ----------------------------------------------------------------------------
module cnw_front #(
  parameter int MAX_DIGITS   = 16,
  parameter int NUMBER_WIDTH = 16,
  parameter int CW           = $clog2(MAX_DIGITS + 1)
) (
  cnw_in_if.sink                    in_ch,
  input  cnw_pkg::cnw_q_stat_t      q_stat,
  output logic                      push,
  output cnw_pkg::cnw_job_ctrl_t    job_ctrl,
  output logic [NUMBER_WIDTH-1:0]   job_value,
  output logic [CW-1:0]             job_count
);
  import cnw_pkg::*;

  localparam int EXT_W = (NUMBER_WIDTH > 16) ? NUMBER_WIDTH : 16;

  logic [EXT_W-1:0]        num_ext;
  logic [NUMBER_WIDTH-1:0] num_w;
  logic [7:0]              col_m1;
  logic [7:0]              addr;
  logic                    mode_ok;

  assign in_ch.ready = ~q_stat.full;

  assign num_ext = EXT_W'(in_ch.number);
  assign num_w   = num_ext[NUMBER_WIDTH-1:0];

  // column counts from 1; column 0 wraps, modulo 256
  assign col_m1 = 8'(in_ch.column) - 8'd1;
  assign addr   = (in_ch.line == LINE_FIRST) ? col_m1 : (col_m1 + LINE2_OFFSET);

  always_comb begin
    mode_ok       = 1'b1;
    job_ctrl.kind = KIND_CURSOR;
    unique case (in_ch.mode)
      MODE_INIT:   job_ctrl.kind = KIND_INIT;
      MODE_CURSOR: job_ctrl.kind = KIND_CURSOR;
      MODE_UDEC:   job_ctrl.kind = KIND_UDEC;
      MODE_SDEC:   job_ctrl.kind = KIND_SDEC;
      MODE_HEX:    job_ctrl.kind = KIND_HEX;
      MODE_BIN:    job_ctrl.kind = KIND_BIN;
      default:     mode_ok       = 1'b0;  // unused modes produce nothing
    endcase
  end

  assign job_ctrl.neg    = (in_ch.mode == MODE_SDEC) && num_w[NUMBER_WIDTH-1];
  assign job_ctrl.cursor = CMD_DDRAM | addr;
  assign job_value       = job_ctrl.neg ? (~num_w + 1'b1) : num_w;
  // set-cursor carries no digits
  assign job_count       = (in_ch.mode == MODE_CURSOR) ? '0 :
                           (32'(in_ch.digit_count) > 32'(MAX_DIGITS)) ?
                           CW'(MAX_DIGITS) : CW'(in_ch.digit_count);

  assign push = in_ch.valid && in_ch.ready && mode_ok;

endmodule

// File: design/cnw_back.sv
// ----------------------------------------------------------------------------
// cnw_back : LCD write sequencer
// Pops jobs, runs a two-bit-per-cycle binary-to-BCD conversion for the
// decimal modes, then emits one bus write per cycle, while the output register is free.
// ----------------------------------------------------------------------------
module cnw_back #(
  parameter int MAX_DIGITS   = 16,
  parameter int NUMBER_WIDTH = 16,
  parameter int CW           = $clog2(MAX_DIGITS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cnw_pkg::cnw_q_stat_t      q_stat,
  input  cnw_pkg::cnw_job_ctrl_t    job_ctrl,
  input  logic [NUMBER_WIDTH-1:0]   job_value,
  input  logic [CW-1:0]             job_count,
  output logic                      pop,
  output cnw_pkg::cnw_back_stat_t   stat,
  cnw_out_if.source                 out_ch
);
  import cnw_pkg::*;

  localparam int W2         = NUMBER_WIDTH + (NUMBER_WIDTH % 2);
  localparam int STEPS      = W2 / 2;
  localparam int SW         = $clog2(STEPS + 1);
  localparam int BCD_DIGITS = ((NUMBER_WIDTH * 3) / 10) + 1;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int BI         = $clog2(BCD_DIGITS);
  localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

  cnw_state_t              state_r, state_nxt;
  cnw_kind_t               kind_r, kind_nxt;
  logic                    neg_r, neg_nxt;
  logic [7:0]              cursor_r, cursor_nxt;
  logic [NUMBER_WIDTH-1:0] value_r, value_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           dig_r, dig_nxt;
  logic [1:0]              init_idx_r, init_idx_nxt;
  logic [SW-1:0]           step_r, step_nxt;
  logic [W2-1:0]           sh_r, sh_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_rs_r, out_rs_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    slot_free;
  logic                    emit;
  logic                    e_rs;
  logic [7:0]              e_byte;
  logic                    e_last;
  logic [BCD_W+W2-1:0]     cat;
  logic [NUMBER_WIDTH-1:0] hex_sh;
  logic [NUMBER_WIDTH-1:0] bin_sh;
  logic [31:0]             dig32;
  logic [BI-1:0]           bidx;
  logic [3:0]              dec_dig;
  logic [3:0]              cur_dig;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = out_rs_r;
  assign out_ch.bus_byte   = out_byte_r;
  assign out_ch.last       = out_last_r;
  assign stat.busy         = (state_r != ST_IDLE);

  assign slot_free = ~out_valid_r | out_ch.ready;

  // two double-dabble steps per cycle
  always_comb begin
    cat = {bcd_r, sh_r};
    for (int s = 0; s < 2; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (cat[W2 + 4*d +: 4] >= 4'd5) begin
          cat[W2 + 4*d +: 4] = cat[W2 + 4*d +: 4] + 4'd3;
        end
      end
      cat = cat << 1;
    end
  end

  // digit selection; digits above the value's width read as zero
  assign hex_sh  = value_r >> {dig_r, 2'b00};
  assign bin_sh  = value_r >> dig_r;
  assign dig32   = 32'(dig_r);
  assign bidx    = dig32[BI-1:0];
  assign dec_dig = (dig32 < 32'(BCD_DIGITS)) ? bcd_r[bidx*4 +: 4] : 4'd0;

  always_comb begin
    unique case (kind_r)
      KIND_HEX: cur_dig = hex_sh[3:0];
      KIND_BIN: cur_dig = {3'b000, bin_sh[0]};
      default:  cur_dig = dec_dig;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    neg_nxt      = neg_r;
    cursor_nxt   = cursor_r;
    value_nxt    = value_r;
    count_nxt    = count_r;
    dig_nxt      = dig_r;
    init_idx_nxt = init_idx_r;
    step_nxt     = step_r;
    sh_nxt       = sh_r;
    bcd_nxt      = bcd_r;
    pop          = 1'b0;
    emit         = 1'b0;
    e_rs         = RS_COMMAND;
    e_byte       = 8'h00;
    e_last       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop          = 1'b1;
          kind_nxt     = job_ctrl.kind;
          neg_nxt      = job_ctrl.neg;
          cursor_nxt   = job_ctrl.cursor;
          value_nxt    = job_value;
          count_nxt    = job_count;
          init_idx_nxt = 2'd0;
          step_nxt     = '0;
          sh_nxt       = W2'(job_value);
          bcd_nxt      = '0;
          unique case (job_ctrl.kind)
            KIND_INIT:            state_nxt = ST_INIT;
            KIND_UDEC, KIND_SDEC: state_nxt = ST_CONVERT;
            default:              state_nxt = ST_CURSOR;
          endcase
        end
      end
      ST_CONVERT: begin
        bcd_nxt  = cat[BCD_W+W2-1:W2];
        sh_nxt   = cat[W2-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_CURSOR;
        end
      end
      ST_INIT: begin
        if (slot_free) begin
          emit         = 1'b1;
          e_rs         = RS_COMMAND;
          e_byte       = init_cmd(init_idx_r);
          e_last       = (init_idx_r == INIT_LAST_IDX);
          init_idx_nxt = init_idx_r + 2'd1;
          if (init_idx_r == INIT_LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CURSOR: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_rs    = RS_COMMAND;
          e_byte  = cursor_r;
          e_last  = (kind_r != KIND_SDEC) && (count_r == '0);
          dig_nxt = count_r - 1'b1;
          if (kind_r == KIND_SDEC) begin
            state_nxt = ST_SIGN;
          end else if (count_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_rs      = RS_DATA;
          e_byte    = neg_r ? ASCII_MINUS : ASCII_PLUS;
          e_last    = (count_r == '0);
          state_nxt = (count_r == '0) ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_rs    = RS_DATA;
          e_byte  = ascii_digit(cur_dig);
          e_last  = (dig_r == '0);
          dig_nxt = dig_r - 1'b1;
          if (dig_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_rs_nxt    = e_rs;
      out_byte_nxt  = e_byte;
      out_last_nxt  = e_last;
    end else begin
      out_valid_nxt = out_valid_r & ~out_ch.ready;
      out_rs_nxt    = out_rs_r;
      out_byte_nxt  = out_byte_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    neg_r      <= neg_nxt;
    cursor_r   <= cursor_nxt;
    value_r    <= value_nxt;
    count_r    <= count_nxt;
    dig_r      <= dig_nxt;
    init_idx_r <= init_idx_nxt;
    step_r     <= step_nxt;
    sh_r       <= sh_nxt;
    bcd_r      <= bcd_nxt;
    out_rs_r   <= out_rs_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
